[design/gcb_pkg.sv]
package gcb_pkg;

  // Width of the internal cluster byte counter; lengths saturate at its maximum.
  localparam int LENGTH_BITS = 16;
  localparam int OUT_BITS    = 16;
  localparam int WIDE_BITS   = (LENGTH_BITS > OUT_BITS) ? LENGTH_BITS : OUT_BITS;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [OUT_BITS-1:0]    OUT_MAX = {OUT_BITS{1'b1}};

  // Grapheme break classes
  localparam logic [3:0] CLS_OTHER   = 4'd0;
  localparam logic [3:0] CLS_CR      = 4'd1;
  localparam logic [3:0] CLS_LF      = 4'd2;
  localparam logic [3:0] CLS_CONTROL = 4'd3;
  localparam logic [3:0] CLS_EXTEND  = 4'd4;
  localparam logic [3:0] CLS_ZWJ     = 4'd5;
  localparam logic [3:0] CLS_RI      = 4'd6;
  localparam logic [3:0] CLS_PREPEND = 4'd7;
  localparam logic [3:0] CLS_SPACING = 4'd8;
  localparam logic [3:0] CLS_L       = 4'd9;
  localparam logic [3:0] CLS_V       = 4'd10;
  localparam logic [3:0] CLS_T       = 4'd11;
  localparam logic [3:0] CLS_LV      = 4'd12;
  localparam logic [3:0] CLS_LVT     = 4'd13;

  // Indic conjunct classes
  localparam logic [1:0] INCB_NONE      = 2'd0;
  localparam logic [1:0] INCB_CONSONANT = 2'd1;
  localparam logic [1:0] INCB_EXTEND    = 2'd2;
  localparam logic [1:0] INCB_LINKER    = 2'd3;

  // Conjunct tracking states
  localparam logic [1:0] CONJ_IDLE      = 2'd0;
  localparam logic [1:0] CONJ_CONSONANT = 2'd1;
  localparam logic [1:0] CONJ_LINKED    = 2'd2;

  typedef struct packed {
    logic [3:0] prev_class;
    logic       ri_odd;
    logic [1:0] conj_state;
    logic       pict_tail;
    logic       zwj_after_pict;
  } rule_state_t;

  typedef struct packed {
    logic [3:0] break_class;
    logic [1:0] conjunct_class;
    logic       pictographic;
    logic [2:0] byte_count;
    logic       start_of_text;
  } item_t;

  localparam rule_state_t RULE_STATE_RESET = '{
    prev_class:     CLS_OTHER,
    ri_odd:         1'b0,
    conj_state:     CONJ_IDLE,
    pict_tail:      1'b0,
    zwj_after_pict: 1'b0
  };

  // Clamp an internal length to the output field width.
  function automatic logic [OUT_BITS-1:0] out_len(input logic [LENGTH_BITS-1:0] v);
    logic [WIDE_BITS-1:0] wide;
    wide = WIDE_BITS'(v);
    if (wide > WIDE_BITS'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

[design/gcb_rules.sv]
module gcb_rules (
  input  gcb_pkg::rule_state_t state,
  input  logic                 sot,
  input  logic [3:0]           break_class,
  input  logic [1:0]           conjunct_class,
  input  logic                 pictographic,
  output logic                 boundary,
  output gcb_pkg::rule_state_t state_next
);

  logic [3:0]           cls;
  logic [3:0]           p;
  logic                 p_ctl;
  logic                 c_ctl;
  logic                 rule_break;
  gcb_pkg::rule_state_t eff;

  // Fold unknown classes onto other.
  always_comb begin
    if (break_class > gcb_pkg::CLS_LVT) begin
      cls = gcb_pkg::CLS_OTHER;
    end else begin
      cls = break_class;
    end
  end

  assign eff   = sot ? gcb_pkg::RULE_STATE_RESET : state;
  assign p     = state.prev_class;
  assign p_ctl = p inside {gcb_pkg::CLS_CR, gcb_pkg::CLS_LF, gcb_pkg::CLS_CONTROL};
  assign c_ctl = cls inside {gcb_pkg::CLS_CR, gcb_pkg::CLS_LF, gcb_pkg::CLS_CONTROL};

  // Rules in priority order, GB3 first.
  always_comb begin
    if (p == gcb_pkg::CLS_CR && cls == gcb_pkg::CLS_LF) begin
      rule_break = 1'b0;
    end else if (p_ctl || c_ctl) begin
      rule_break = 1'b1;
    end else if (p == gcb_pkg::CLS_L && (cls inside {gcb_pkg::CLS_L, gcb_pkg::CLS_V,
                                                     gcb_pkg::CLS_LV, gcb_pkg::CLS_LVT})) begin
      rule_break = 1'b0;
    end else if ((p inside {gcb_pkg::CLS_LV, gcb_pkg::CLS_V}) &&
                 (cls inside {gcb_pkg::CLS_V, gcb_pkg::CLS_T})) begin
      rule_break = 1'b0;
    end else if ((p inside {gcb_pkg::CLS_LVT, gcb_pkg::CLS_T}) && cls == gcb_pkg::CLS_T) begin
      rule_break = 1'b0;
    end else if (cls inside {gcb_pkg::CLS_EXTEND, gcb_pkg::CLS_ZWJ, gcb_pkg::CLS_SPACING}) begin
      rule_break = 1'b0;
    end else if (p == gcb_pkg::CLS_PREPEND) begin
      rule_break = 1'b0;
    end else if (conjunct_class == gcb_pkg::INCB_CONSONANT &&
                 state.conj_state == gcb_pkg::CONJ_LINKED) begin
      rule_break = 1'b0;
    end else if (state.zwj_after_pict && pictographic) begin
      rule_break = 1'b0;
    end else if (p == gcb_pkg::CLS_RI && cls == gcb_pkg::CLS_RI && state.ri_odd) begin
      rule_break = 1'b0;
    end else begin
      rule_break = 1'b1;
    end
  end

  assign boundary = sot || rule_break;

  // Advance the forward state that stands in for the backward scans.
  always_comb begin
    state_next.prev_class = cls;
    state_next.ri_odd     = (cls == gcb_pkg::CLS_RI) &&
                            !(eff.prev_class == gcb_pkg::CLS_RI && eff.ri_odd);
    case (conjunct_class)
      gcb_pkg::INCB_CONSONANT: state_next.conj_state = gcb_pkg::CONJ_CONSONANT;
      gcb_pkg::INCB_LINKER: begin
        state_next.conj_state = (eff.conj_state != gcb_pkg::CONJ_IDLE) ?
                                gcb_pkg::CONJ_LINKED : gcb_pkg::CONJ_IDLE;
      end
      gcb_pkg::INCB_EXTEND: state_next.conj_state = eff.conj_state;
      default: state_next.conj_state = gcb_pkg::CONJ_IDLE;
    endcase
    state_next.zwj_after_pict = (cls == gcb_pkg::CLS_ZWJ) && eff.pict_tail;
    state_next.pict_tail      = pictographic || (cls == gcb_pkg::CLS_EXTEND && eff.pict_tail);
  end

endmodule

[design/gcb_length.sv]
module gcb_length (
  input  logic [gcb_pkg::LENGTH_BITS-1:0] cluster_bytes,
  input  logic                            boundary,
  input  logic [2:0]                      byte_count,
  output logic [gcb_pkg::LENGTH_BITS-1:0] cluster_bytes_next,
  output logic [gcb_pkg::OUT_BITS-1:0]    closed_len,
  output logic [gcb_pkg::OUT_BITS-1:0]    open_len
);

  logic [gcb_pkg::LENGTH_BITS-1:0] base;
  logic [gcb_pkg::LENGTH_BITS:0]   sum;

  // Restart the count on a boundary, otherwise extend it; saturate.
  assign base = boundary ? '0 : cluster_bytes;
  assign sum  = {1'b0, base} + (gcb_pkg::LENGTH_BITS + 1)'(byte_count);

  always_comb begin
    if (sum > {1'b0, gcb_pkg::LEN_MAX}) begin
      cluster_bytes_next = gcb_pkg::LEN_MAX;
    end else begin
      cluster_bytes_next = sum[gcb_pkg::LENGTH_BITS-1:0];
    end
  end

  assign closed_len = boundary ? gcb_pkg::out_len(cluster_bytes) : '0;
  assign open_len   = gcb_pkg::out_len(cluster_bytes_next);

endmodule

[design/grapheme_cluster_breaker.sv]
// Extended grapheme cluster boundary finder (UAX #29, rules GB3 to GB999 with
// regional indicator pairing, Indic conjuncts and emoji ZWJ sequences). Feed
// one pre-classified code point per item; each item gives exactly one result
// item carrying the break-before flag, the byte length of the cluster that
// the break closes (0 when there is no break) and the running byte length of
// the open cluster. Lengths saturate at 65535. Set start_of_text on the
// first code point of a text; the first item after reset is treated the same
// way. Throughput is one item per clock while the result register is being
// drained: an item is taken into an input register, decided in one pass of
// rule logic against a handful of state bits, and written to a result
// register, which raises out_valid. While a result waits, the input side
// takes at most one more item and then stalls until out_ready frees the
// result register.
module grapheme_cluster_breaker (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  break_class,
  input  logic [1:0]  conjunct_class,
  input  logic        pictographic,
  input  logic [2:0]  byte_count,
  input  logic        start_of_text,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        boundary_before,
  output logic [15:0] closed_length,
  output logic [15:0] open_length
);

  // Input register
  logic                            item_valid;
  gcb_pkg::item_t                  item;

  // Rule state and open cluster count
  gcb_pkg::rule_state_t            rule_state;
  gcb_pkg::rule_state_t            rule_state_next;
  logic [gcb_pkg::LENGTH_BITS-1:0] cluster_bytes;
  logic [gcb_pkg::LENGTH_BITS-1:0] cluster_bytes_next;

  logic                            advance;
  logic                            sot;
  logic                            boundary;
  logic [gcb_pkg::OUT_BITS-1:0]    closed_len;
  logic [gcb_pkg::OUT_BITS-1:0]    open_len;

  // Move the held item into the result register whenever that register is
  // empty or its contents are being taken this cycle.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Hold the accepted item until it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.break_class    <= break_class;
      item.conjunct_class <= conjunct_class;
      item.pictographic   <= pictographic;
      item.byte_count     <= byte_count;
      item.start_of_text  <= start_of_text;
    end
  end

  // An empty open cluster means there is nothing to continue: start afresh.
  assign sot = item.start_of_text || (cluster_bytes == '0);

  gcb_rules u_rules (
    .state          (rule_state),
    .sot            (sot),
    .break_class    (item.break_class),
    .conjunct_class (item.conjunct_class),
    .pictographic   (item.pictographic),
    .boundary       (boundary),
    .state_next     (rule_state_next)
  );

  gcb_length u_length (
    .cluster_bytes      (cluster_bytes),
    .boundary           (boundary),
    .byte_count         (item.byte_count),
    .cluster_bytes_next (cluster_bytes_next),
    .closed_len         (closed_len),
    .open_len           (open_len)
  );

  // Commit the state only as the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_state    <= gcb_pkg::RULE_STATE_RESET;
      cluster_bytes <= '0;
    end else if (advance) begin
      rule_state    <= rule_state_next;
      cluster_bytes <= cluster_bytes_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      boundary_before <= boundary;
      closed_length   <= closed_len;
      open_length     <= open_len;
    end
  end

endmodule

[design/gcb_checker.sv]
module gcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        boundary_before,
  input logic [15:0] closed_length,
  input logic [15:0] open_length
);

  // A result waiting to be taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // No cluster is closed without a boundary.
  a_closed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !boundary_before |-> closed_length == 16'd0)
    else $error("closed length reported without a boundary");

  // A continued cluster can never be empty.
  a_open_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !boundary_before |-> open_length != 16'd0)
    else $error("continued cluster has zero length");

  // With the result register empty the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // Nothing comes out of reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind grapheme_cluster_breaker gcb_checker u_gcb_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .boundary_before (boundary_before),
  .closed_length   (closed_length),
  .open_length     (open_length)
);
